[rtl/global_lp_norm_pool_defines.svh]
// Assertion helpers shared by the RTL files.
`ifndef GLOBAL_LP_NORM_POOL_DEFINES_SVH
`define GLOBAL_LP_NORM_POOL_DEFINES_SVH

// Checked only out of reset.
`define LPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define LPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lpp_pkg.sv]
package lpp_pkg;

  localparam int LPP_SAMPLE_W = 16;
  localparam int LPP_MAG_W    = 17;
  localparam int LPP_TERM_W   = 31;
  localparam int LPP_ACC_W    = 43;
  localparam int LPP_RES_W    = 44;
  localparam int LPP_NORM_W   = 28;
  localparam int LPP_Q_DEPTH  = 4;

  localparam int LPP_ROOT_STEPS = 22;
  localparam int LPP_STEP_W     = $clog2(LPP_ROOT_STEPS);

  localparam logic [LPP_ACC_W-1:0] LPP_ACC_MAX  = {LPP_ACC_W{1'b1}};
  localparam logic [LPP_ACC_W-1:0] LPP_NORM_MAX = 43'd134217728;
  localparam logic [LPP_ACC_W-1:0] LPP_ROOT_BIT0 = 43'd1 << (LPP_ACC_W - 1);

  localparam logic [1:0] ORDER_P1    = 2'd1;
  localparam logic [1:0] ORDER_RESET = 2'd2;

  typedef struct packed {
    logic signed [LPP_SAMPLE_W-1:0] sample;
    logic                           plane_end;
  } lpp_in_t;

  typedef struct packed {
    logic [LPP_NORM_W-1:0] norm;
    logic                  saturated;
  } lpp_out_t;

  // One finished plane handed from front to back.
  typedef struct packed {
    logic [LPP_ACC_W-1:0] acc;
    logic                 ovf;
    logic                 p1;
  } lpp_job_t;

  typedef struct packed {
    logic empty;
    logic almost_full;
    logic full;
  } lpp_qstat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_HOLD
  } lpp_state_t;

endpackage

[rtl/global_lp_norm_pool.sv]
// A plane_end transfer reaches out_valid through the s1 register, the plane queue and the output register.
// Throughput: one sample per cycle unless in_stall is high; the back end takes one plane
// at a time, and p=2 planes go through the 22-step shared square-root loop.
// A 4-entry plane queue lets sampling continue while roots are computed.
// Reset: synchronous active-low rst_n clears the accumulator, queue and output valid
// and sets norm_order to 2.
module global_lp_norm_pool #(
  parameter int Q_DEPTH = lpp_pkg::LPP_Q_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lpp_pkg::lpp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lpp_pkg::lpp_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data
);
  import lpp_pkg::*;

  logic       push;
  logic       pop;
  lpp_job_t   job_in;
  lpp_job_t   job_out;
  lpp_qstat_t qstat;

  lpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push),
    .job       (job_in)
  );

  lpp_queue #(.Q_DEPTH(Q_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (job_in),
    .pop   (pop),
    .dout  (job_out),
    .qstat (qstat)
  );

  lpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .job       (job_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/lpp_front.sv]
module lpp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lpp_pkg::lpp_in_t   in_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data,
  input  lpp_pkg::lpp_qstat_t qstat,
  output logic               push,
  output lpp_pkg::lpp_job_t  job
);
  import lpp_pkg::*;

  logic [1:0]            norm_order_r, norm_order_nxt;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_last_r, s1_last_nxt;
  logic                  s1_p1_r, s1_p1_nxt;
  logic [LPP_TERM_W-1:0] s1_term_r, s1_term_nxt;
  logic [LPP_ACC_W-1:0]  acc_r, acc_nxt;
  logic                  ovf_r, ovf_nxt;

  logic                     in_xfer;
  logic                     p1;
  logic [LPP_MAG_W-1:0]     mag;
  logic [2*LPP_MAG_W-1:0]   sq;
  logic [LPP_RES_W-1:0]     sum;
  logic                     of;
  logic [LPP_ACC_W-1:0]     sum_sat;

  assign cfg_ready = 1'b1;
  // A plane end held in s1 pushes this cycle, so reserve its queue slot.
  assign in_stall = qstat.full || (qstat.almost_full && s1_valid_r && s1_last_r);
  assign in_xfer  = in_valid && !in_stall;
  assign p1       = (norm_order_r == ORDER_P1);

  always_comb begin
    mag = in_data.sample[LPP_SAMPLE_W-1]
        ? LPP_MAG_W'(17'h10000 - {1'b0, in_data.sample})
        : {1'b0, in_data.sample};
    sq  = mag * mag;
    norm_order_nxt = (cfg_valid && cfg_ready) ? cfg_data : norm_order_r;
    s1_valid_nxt = in_xfer;
    s1_last_nxt  = in_xfer ? in_data.plane_end : s1_last_r;
    s1_p1_nxt    = in_xfer ? p1 : s1_p1_r;
    s1_term_nxt  = s1_term_r;
    if (in_xfer) begin
      s1_term_nxt = p1 ? LPP_TERM_W'(mag) : LPP_TERM_W'(sq);
    end
  end

  always_comb begin
    sum     = {1'b0, acc_r} + LPP_RES_W'(s1_term_r);
    of      = sum[LPP_RES_W-1];
    sum_sat = of ? LPP_ACC_MAX : sum[LPP_ACC_W-1:0];
    push    = s1_valid_r && s1_last_r;
    job     = '{acc: sum_sat, ovf: ovf_r | of, p1: s1_p1_r};
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    if (s1_valid_r) begin
      if (s1_last_r) begin
        acc_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        acc_nxt = sum_sat;
        ovf_nxt = ovf_r | of;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_order_r <= ORDER_RESET;
      s1_valid_r   <= 1'b0;
      s1_last_r    <= 1'b0;
      acc_r        <= '0;
      ovf_r        <= 1'b0;
    end else begin
      norm_order_r <= norm_order_nxt;
      s1_valid_r   <= s1_valid_nxt;
      s1_last_r    <= s1_last_nxt;
      acc_r        <= acc_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_p1_r   <= s1_p1_nxt;
    s1_term_r <= s1_term_nxt;
  end

endmodule

[rtl/lpp_queue.sv]
`include "global_lp_norm_pool_defines.svh"

module lpp_queue #(
  parameter int Q_DEPTH = lpp_pkg::LPP_Q_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpp_pkg::lpp_job_t   din,
  input  logic                pop,
  output lpp_pkg::lpp_job_t   dout,
  output lpp_pkg::lpp_qstat_t qstat
);
  import lpp_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(Q_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(Q_DEPTH);
  localparam logic [CW-1:0] AF_CNT   = CW'(Q_DEPTH - 1);

  lpp_job_t        entry_r [Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign dout              = entry_r[rd_ptr_r];
  assign qstat.empty       = (count_r == '0);
  assign qstat.full        = (count_r == FULL_CNT);
  assign qstat.almost_full = (count_r >= AF_CNT);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

  `LPP_ASSERT(a_no_push_full, push |-> !qstat.full, "push into full queue")
  `LPP_ASSERT(a_no_pop_empty, pop |-> !qstat.empty, "pop from empty queue")
  `LPP_ASSERT(a_count_range, count_r <= FULL_CNT, "queue count out of range")

endmodule

[rtl/lpp_back.sv]
`include "global_lp_norm_pool_defines.svh"

module lpp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lpp_pkg::lpp_qstat_t qstat,
  input  lpp_pkg::lpp_job_t   job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output lpp_pkg::lpp_out_t   out_data
);
  import lpp_pkg::*;

  lpp_state_t            state_r, state_nxt;
  logic [LPP_ACC_W-1:0]  v_r, v_nxt;
  logic [LPP_RES_W-1:0]  res_r, res_nxt;
  logic [LPP_ACC_W-1:0]  bit_r, bit_nxt;
  logic [LPP_STEP_W-1:0] step_r, step_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  p1_r, p1_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lpp_out_t              out_data_r, out_data_nxt;

  logic                  load_out;
  logic                  last_step;
  logic [LPP_RES_W-1:0]  trial;
  logic                  ge;
  lpp_out_t              result;

  assign pop       = (state_r == ST_IDLE) && !qstat.empty;
  assign load_out  = (state_r == ST_HOLD) && (!out_valid_r || !out_stall);
  assign last_step = (step_r == LPP_STEP_W'(LPP_ROOT_STEPS - 1));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt = job.p1 ? ST_HOLD : ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (last_step) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    // One digit-pair of the restoring square root per cycle.
    trial = res_r + {1'b0, bit_r};
    ge    = ({1'b0, v_r} >= trial);

    if (p1_r) begin
      if (v_r > LPP_NORM_MAX) begin
        result = '{norm: LPP_NORM_MAX[LPP_NORM_W-1:0], saturated: 1'b1};
      end else begin
        result = '{norm: v_r[LPP_NORM_W-1:0], saturated: ovf_r};
      end
    end else begin
      result = '{norm: res_r[LPP_NORM_W-1:0], saturated: ovf_r};
    end

    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    step_nxt = step_r;
    ovf_nxt  = ovf_r;
    p1_nxt   = p1_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          v_nxt    = job.acc;
          res_nxt  = '0;
          bit_nxt  = LPP_ROOT_BIT0;
          step_nxt = '0;
          ovf_nxt  = job.ovf;
          p1_nxt   = job.p1;
        end
      end
      ST_ROOT: begin
        if (ge) begin
          v_nxt   = LPP_ACC_W'({1'b0, v_r} - trial);
          res_nxt = (res_r >> 1) + {1'b0, bit_r};
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        step_nxt = step_r + LPP_STEP_W'(1);
      end
      default: ;
    endcase

    out_data_nxt  = load_out ? result : out_data_r;
    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    res_r      <= res_nxt;
    bit_r      <= bit_nxt;
    step_r     <= step_nxt;
    ovf_r      <= ovf_nxt;
    p1_r       <= p1_nxt;
    out_data_r <= out_data_nxt;
  end

  `LPP_ASSERT(a_pop_idle, pop |-> state_r == ST_IDLE, "queue popped outside idle")
  `LPP_ASSERT(a_hold_loads, load_out |=> out_valid_r, "finished plane not presented")
  `LPP_ASSERT(a_norm_range,
    out_valid_r |-> {15'd0, out_data_r.norm} <= LPP_NORM_MAX, "norm above clip level")

endmodule

[sim/global_lp_norm_pool_checker.sv]
`timescale 1ns / 1ps

module global_lp_norm_pool_checker
  import lpp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  lpp_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  lpp_out_t out_data,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  logic [1:0] cfg_data,
  output int       fail_count,
  output int       norms_pending,
  output int       planes_checked,
  output int       sat_planes
);

  logic [1:0]           order_q;
  logic [LPP_ACC_W-1:0] plane_sum;
  logic                 sum_clipped;
  lpp_out_t             norm_q[$];
  int                   errs;
  int                   n_checked;
  int                   n_sat;

  always @(posedge clk) begin : predict_and_check
    logic        p1;
    logic [16:0] mag;
    logic [63:0] sum;
    logic [63:0] n;
    logic [63:0] root;
    logic [63:0] cand;
    logic        sat;
    lpp_out_t    want;
    int          b;

    if (!rst_n) begin
      order_q     = ORDER_RESET;
      plane_sum   = '0;
      sum_clipped = 1'b0;
      norm_q.delete();
      errs      = 0;
      n_checked = 0;
      n_sat     = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        order_q = cfg_data;

      if (in_valid && !in_stall) begin
        // each sample is folded in the order that is live when it arrives
        p1  = (order_q == ORDER_P1);
        mag = in_data.sample[15] ? -{1'b1, in_data.sample} : {1'b0, in_data.sample};
        sum = 64'(plane_sum) + (p1 ? 64'(mag) : 64'(mag) * 64'(mag));
        if (sum > 64'(LPP_ACC_MAX)) begin
          sum         = 64'(LPP_ACC_MAX);
          sum_clipped = 1'b1;
        end
        plane_sum = sum[LPP_ACC_W-1:0];

        if (in_data.plane_end) begin
          sat = sum_clipped;
          if (p1) begin
            n = 64'(plane_sum);
            if (n > 64'(LPP_NORM_MAX)) begin
              n   = 64'(LPP_NORM_MAX);
              sat = 1'b1;
            end
          end else begin
            // floor square root, one result bit at a time
            root = 0;
            for (b = 21; b >= 0; b--) begin
              cand = root | (64'd1 << b);
              if (cand * cand <= 64'(plane_sum))
                root = cand;
            end
            n = root;
          end
          want.norm      = n[LPP_NORM_W-1:0];
          want.saturated = sat;
          norm_q.push_back(want);
          plane_sum   = '0;
          sum_clipped = 1'b0;
        end
      end

      if (out_valid && !out_stall) begin
        if (norm_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result: norm %0d saturated %0b",
                     out_data.norm, out_data.saturated);
        end else begin
          want = norm_q.pop_front();
          n_checked++;
          if (want.saturated)
            n_sat++;
          if (out_data.norm !== want.norm || out_data.saturated !== want.saturated) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: norm exp %0d got %0d, saturated exp %0b got %0b",
                       want.norm, out_data.norm, want.saturated, out_data.saturated);
          end
        end
      end
    end

    fail_count     <= errs;
    norms_pending  <= norm_q.size();
    planes_checked <= n_checked;
    sat_planes     <= n_sat;
  end

endmodule

[sim/global_lp_norm_pool_tb.sv]
`timescale 1ns / 1ps

module global_lp_norm_pool_tb;
  import lpp_pkg::*;

  localparam logic [1:0] ORDER_UNDEF_LO = 2'd0;
  localparam logic [1:0] ORDER_UNDEF_HI = 2'd3;
  localparam int SETTLE_CYCLES = 30;    // lets the root unit go quiet after the last result
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SEG_ITEMS     = 175;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  lpp_in_t    in_data;
  logic       out_valid;
  logic       out_stall;
  lpp_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;

  int fail_count;
  int norms_pending;
  int planes_checked;
  int sat_planes;

  int tx_idle_pct;
  int rx_idle_pct;
  logic hold_req;
  logic hold_taken;
  int hold_left;
  int quiet_cycles;
  int samples_sent;

  always #5 clk = ~clk;

  global_lp_norm_pool DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  global_lp_norm_pool_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .norms_pending  (norms_pending),
    .planes_checked (planes_checked),
    .sat_planes     (sat_planes)
  );

  // result side: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      hold_taken <= 1'b0;
      hold_left  <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("[global_lp_norm_pool] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(input logic signed [15:0] s, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.sample    <= s;
    in_data.plane_end <= last;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // drop valid and wait until every plane result is back and the root unit is quiet
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (norms_pending != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_order(input logic [1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_planes(input int n_items);
    int len;
    int k;
    int sent;
    logic signed [15:0] s;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(99);
      if (k < 70)      len = $urandom_range(8, 1);
      else if (k < 95) len = $urandom_range(40, 9);
      else             len = $urandom_range(300, 41);
      // a segment may stop mid-plane; the plane then finishes under the next order
      for (k = 0; k < len && sent < n_items; k++) begin
        case ($urandom_range(7))
          0:       s = 16'sh8000;
          1:       s = 16'sh7fff;
          2:       s = 16'sh0000;
          3:       s = 16'($signed($urandom_range(511)) - 256);
          default: s = 16'($urandom);
        endcase
        push_sample(s, k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = ORDER_RESET;
    hold_req     = 1'b0;
    tx_idle_pct  = 24;
    rx_idle_pct  = 83;
    samples_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // root of squares, order from reset
    push_sample(16'sh0000, 1'b1);
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sh7fff, 1'b1);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd1, 1'b0);
    push_sample(16'sd256, 1'b0);
    push_sample(-16'sd256, 1'b1);
    drain();

    write_order(ORDER_P1);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(-16'sd1, 1'b1);
    push_sample(16'sh0000, 1'b1);
    // order switched mid-plane: magnitudes first, then a square and a root
    push_sample(16'sd100, 1'b0);
    push_sample(-16'sd100, 1'b0);
    drain();
    write_order(ORDER_RESET);
    push_sample(16'sd16, 1'b1);

    // squares in, plane closed as a magnitude sum: norm clips at its ceiling
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    drain();
    write_order(ORDER_P1);
    push_sample(16'sh8000, 1'b1);
    drain();

    write_order(ORDER_UNDEF_HI);
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sd300, 1'b1);
    drain();

    write_order(ORDER_P1);
    random_planes(SEG_ITEMS);
    drain();
    write_order(ORDER_UNDEF_LO);
    random_planes(SEG_ITEMS);
    drain();

    tx_idle_pct = 83;
    rx_idle_pct <= 24;
    write_order(ORDER_UNDEF_HI);
    random_planes(SEG_ITEMS);
    drain();
    write_order(ORDER_RESET);
    random_planes(SEG_ITEMS);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    write_order(ORDER_P1);
    hold_req <= 1'b1;
    random_planes(SEG_ITEMS);
    drain();
    write_order(ORDER_RESET);
    random_planes(SEG_ITEMS);
    push_sample(16'sh7fff, 1'b1);
    drain();

    $display("sent %0d samples, checked %0d plane norms (%0d flagged saturated)",
             samples_sent, planes_checked, sat_planes);
    $display("orders 0..3 exercised, incl. mid-plane order switches and a long output hold-off");
    if (fail_count == 0) begin
      $display("[global_lp_norm_pool] OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("[global_lp_norm_pool] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/lpp_pkg.sv
rtl/lpp_front.sv
rtl/lpp_queue.sv
rtl/lpp_back.sv
rtl/global_lp_norm_pool.sv
sim/global_lp_norm_pool_checker.sv
sim/global_lp_norm_pool_tb.sv
